// ===== sv/spring_follow_camera_step_core_defines.svh =====
// Assertion macros shared by the spring-follow camera RTL.
`ifndef SPRING_FOLLOW_CAMERA_STEP_CORE_DEFINES_SVH
`define SPRING_FOLLOW_CAMERA_STEP_CORE_DEFINES_SVH
`ifndef SYNTH
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define SFC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/sfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned CFG_W         = 31;
    localparam int unsigned FACING_W      = 18;
    localparam int unsigned DT_W          = 16;
    localparam int unsigned LANES         = 3;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned MUL_W         = DATA_W + 1;
    localparam int unsigned PROD_W        = 2 * MUL_W;

    // Integer parts of the register reset values.
    localparam int unsigned K_INT      = 64;
    localparam int unsigned D_INT      = 16;
    localparam int unsigned BEHIND_INT = 350;
    localparam int unsigned ABOVE_INT  = 150;
    localparam int unsigned LOOK_INT   = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRING    = 3'd0,
        CFG_DAMPING   = 3'd1,
        CFG_BEHIND    = 3'd2,
        CFG_ABOVE     = 3'd3,
        CFG_LOOKAHEAD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] eye;
        logic [DATA_W-1:0] aim;
    } t_lane_res;

    function automatic logic [CFG_W-1:0] cfg_reset_val(input int unsigned ip,
                                                       input int unsigned frac);
        logic [63:0] v;
        v = 64'(ip) << frac;
        if (v > 64'h7FFF_FFFF) begin
            return '1;
        end
        return v[CFG_W-1:0];
    endfunction

    // Clamp a wide signed value into the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1])) begin
            return v[DATA_W-1:0];
        end
        if (v[PROD_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic signed [PROD_W-1:0] wide(input logic signed [DATA_W-1:0] x);
        return {{(PROD_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic logic signed [PROD_W-1:0] wide_u(input logic [CFG_W-1:0] x);
        return {{(PROD_W-CFG_W){1'b0}}, x};
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sfc_in_if;
    import sfc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [DT_W-1:0]            time_step;
    logic signed [DATA_W-1:0]   owner_x;
    logic signed [DATA_W-1:0]   owner_y;
    logic signed [DATA_W-1:0]   owner_z;
    logic signed [FACING_W-1:0] facing_x;
    logic signed [FACING_W-1:0] facing_y;
    logic signed [FACING_W-1:0] facing_z;

    modport source (
        output valid, command, time_step, owner_x, owner_y, owner_z,
               facing_x, facing_y, facing_z,
        input  ready
    );

    modport sink (
        input  valid, command, time_step, owner_x, owner_y, owner_z,
               facing_x, facing_y, facing_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sfc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sfc_out_if;
    import sfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] eye_x;
    logic signed [DATA_W-1:0] eye_y;
    logic signed [DATA_W-1:0] eye_z;
    logic signed [DATA_W-1:0] aim_x;
    logic signed [DATA_W-1:0] aim_y;
    logic signed [DATA_W-1:0] aim_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
        input  ready
    );

    modport sink (
        input  valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sfc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfc_lane #(
    parameter int unsigned FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_snap,
    input  wire logic [sfc_pkg::DT_W-1:0]            i_dt,
    input  wire logic signed [sfc_pkg::DATA_W-1:0]   i_owner,
    input  wire logic signed [sfc_pkg::FACING_W-1:0] i_facing,
    input  wire logic [sfc_pkg::CFG_W-1:0]           i_k,
    input  wire logic [sfc_pkg::CFG_W-1:0]           i_d,
    input  wire logic [sfc_pkg::CFG_W-1:0]           i_behind,
    input  wire logic [sfc_pkg::CFG_W-1:0]           i_look,
    input  wire logic [sfc_pkg::CFG_W-1:0]           i_above,
    input  wire logic                                i_take,
    output sfc_pkg::t_lane_res                       o_res,
    output logic                                     o_idle
);
    import sfc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_MB   = 13'b0000000000010,
        S_ML   = 13'b0000000000100,
        S_AIM  = 13'b0000000001000,
        S_DIFF = 13'b0000000010000,
        S_KD   = 13'b0000000100000,
        S_DV   = 13'b0000001000000,
        S_ACC  = 13'b0000010000000,
        S_VDT  = 13'b0000100000000,
        S_VEL  = 13'b0001000000000,
        S_PDT  = 13'b0010000000000,
        S_POS  = 13'b0100000000000,
        S_HOLD = 13'b1000000000000
    } t_lane_state;

    t_lane_state r_state, n_state;

    logic                       r_snap;
    logic [DT_W-1:0]            r_dt;
    logic signed [DATA_W-1:0]   r_owner;
    logic signed [FACING_W-1:0] r_facing;
    logic signed [DATA_W-1:0]   r_mb, r_ml, r_ideal, r_aim, r_diff;
    logic signed [DATA_W-1:0]   r_t1, r_t2, r_acc;
    logic signed [DATA_W-1:0]   r_pos, r_vel;

    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod, w_shift;
    logic                     w_dt_sh;
    logic signed [DATA_W-1:0] w_mres;

    // One shared multiplier; the state picks its operands.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_dt_sh = 1'b0;
        case (r_state)
            S_MB: begin
                w_mul_a = {{(MUL_W-FACING_W){r_facing[FACING_W-1]}}, r_facing};
                w_mul_b = {{(MUL_W-CFG_W){1'b0}}, i_behind};
            end
            S_ML: begin
                w_mul_a = {{(MUL_W-FACING_W){r_facing[FACING_W-1]}}, r_facing};
                w_mul_b = {{(MUL_W-CFG_W){1'b0}}, i_look};
            end
            S_KD: begin
                w_mul_a = {{(MUL_W-CFG_W){1'b0}}, i_k};
                w_mul_b = {r_diff[DATA_W-1], r_diff};
            end
            S_DV: begin
                w_mul_a = {{(MUL_W-CFG_W){1'b0}}, i_d};
                w_mul_b = {r_vel[DATA_W-1], r_vel};
            end
            S_VDT: begin
                w_mul_a = {r_acc[DATA_W-1], r_acc};
                w_mul_b = {{(MUL_W-DT_W){1'b0}}, r_dt};
                w_dt_sh = 1'b1;
            end
            S_PDT: begin
                w_mul_a = {r_vel[DATA_W-1], r_vel};
                w_mul_b = {{(MUL_W-DT_W){1'b0}}, r_dt};
                w_dt_sh = 1'b1;
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    // Arithmetic shift of the signed product rounds toward minus infinity.
    assign w_prod  = w_mul_a * w_mul_b;
    assign w_shift = w_dt_sh ? (w_prod >>> DT_W) : (w_prod >>> FRAC_BITS);
    assign w_mres  = sat32(w_shift);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_MB;
            S_MB:    n_state = S_ML;
            S_ML:    n_state = S_AIM;
            S_AIM:   n_state = S_DIFF;
            S_DIFF:  n_state = r_snap ? S_HOLD : S_KD;
            S_KD:    n_state = S_DV;
            S_DV:    n_state = S_ACC;
            S_ACC:   n_state = S_VDT;
            S_VDT:   n_state = S_VEL;
            S_VEL:   n_state = S_PDT;
            S_PDT:   n_state = S_POS;
            S_POS:   n_state = S_HOLD;
            S_HOLD:  if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_vel   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_DIFF: begin
                    if (r_snap) begin
                        r_pos <= r_ideal;
                        r_vel <= '0;
                    end
                end
                S_VEL:   r_vel <= sat32(wide(r_vel) + wide(r_t1));
                S_POS:   r_pos <= sat32(wide(r_pos) + wide(r_t1));
                default: r_pos <= r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_snap   <= i_snap;
                    r_dt     <= i_dt;
                    r_owner  <= i_owner;
                    r_facing <= i_facing;
                end
            end
            S_MB: r_mb <= w_mres;
            S_ML: begin
                r_ml    <= w_mres;
                r_ideal <= sat32(wide(r_owner) - wide(r_mb));
            end
            S_AIM: begin
                r_aim   <= sat32(wide(r_owner) + wide(r_ml));
                r_ideal <= sat32(wide(r_ideal) + wide_u(i_above));
            end
            S_DIFF:  r_diff <= sat32(wide(r_pos) - wide(r_ideal));
            S_KD:    r_t1 <= w_mres;
            S_DV:    r_t2 <= w_mres;
            S_ACC:   r_acc <= sat32(-wide(r_t1) - wide(r_t2));
            S_VDT:   r_t1 <= w_mres;
            S_PDT:   r_t1 <= w_mres;
            default: r_t2 <= r_t2;
        endcase
    end

    assign o_res.done = (r_state == S_HOLD);
    assign o_res.eye  = r_pos;
    assign o_res.aim  = r_aim;
    assign o_idle     = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== sv/sfc_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfc_merge (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire sfc_pkg::t_lane_res i_res [sfc_pkg::LANES],
    output logic             o_take,
    sfc_out_if.source        o_out
);
    import sfc_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_eye [LANES];
    logic [DATA_W-1:0] r_aim [LANES];
    logic              w_all_done;

    always_comb begin
        w_all_done = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            w_all_done = w_all_done & i_res[i].done;
        end
    end

    // The output register frees up in the same cycle its transfer completes.
    assign o_take = w_all_done && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int i = 0; i < LANES; i++) begin
                r_eye[i] <= i_res[i].eye;
                r_aim[i] <= i_res[i].aim;
            end
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.eye_x = r_eye[0];
    assign o_out.eye_y = r_eye[1];
    assign o_out.eye_z = r_eye[2];
    assign o_out.aim_x = r_aim[0];
    assign o_out.aim_y = r_aim[1];
    assign o_out.aim_z = r_aim[2];

endmodule

`default_nettype wire

// ===== sv/spring_follow_camera_step_core.sv =====
// Spring-follow camera step.
// Input channel i_in: one transfer per frame carries the owner position, its
// forward vector, a time step and a command (update or snap). Output channel
// o_out: one transfer per input with the new eye position and the aim point.
// The configuration port writes one register per cycle while i_cfg_we is
// high; write it only while no item is in flight.
// Three lanes, one per axis, each step their own multiplier through a fixed
// sequence. An update item runs 11 lane steps and a snap 4; each lane then
// holds its result until all three results move into the output register.
// A new item is taken once all lanes are idle, so none is taken while an item
// is still in the lanes. The output register holds a finished result while the
// receiver stalls; the lanes then wait with the next result and take no new
// item until it moves into the output register.
// Synchronous reset clears eye position and velocity to zero, loads the
// register defaults (k 64, d 16, behind 350, above 150, lookahead 100) and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "spring_follow_camera_step_core_defines.svh"

module spring_follow_camera_step_core #(
    parameter int unsigned FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sfc_pkg::CFG_W-1:0]     i_cfg_data,
    sfc_in_if.sink                             i_in,
    sfc_out_if.source                          o_out
);
    import sfc_pkg::*;

    localparam logic [CFG_W-1:0] K_RST      = cfg_reset_val(K_INT, FRAC_BITS);
    localparam logic [CFG_W-1:0] D_RST      = cfg_reset_val(D_INT, FRAC_BITS);
    localparam logic [CFG_W-1:0] BEHIND_RST = cfg_reset_val(BEHIND_INT, FRAC_BITS);
    localparam logic [CFG_W-1:0] ABOVE_RST  = cfg_reset_val(ABOVE_INT, FRAC_BITS);
    localparam logic [CFG_W-1:0] LOOK_RST   = cfg_reset_val(LOOK_INT, FRAC_BITS);

    logic [CFG_W-1:0] r_k, r_d, r_behind, r_above, r_look;

    logic signed [DATA_W-1:0]   w_owner  [LANES];
    logic signed [FACING_W-1:0] w_facing [LANES];
    logic [CFG_W-1:0]           w_above  [LANES];
    t_lane_res                  w_res    [LANES];
    logic [LANES-1:0]           w_idle;
    logic                       w_start;
    logic                       w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= K_RST;
            r_d      <= D_RST;
            r_behind <= BEHIND_RST;
            r_above  <= ABOVE_RST;
            r_look   <= LOOK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPRING:    r_k      <= i_cfg_data;
                CFG_DAMPING:   r_d      <= i_cfg_data;
                CFG_BEHIND:    r_behind <= i_cfg_data;
                CFG_ABOVE:     r_above  <= i_cfg_data;
                CFG_LOOKAHEAD: r_look   <= i_cfg_data;
                default:       r_k      <= r_k;
            endcase
        end
    end

    assign w_owner[0]  = i_in.owner_x;
    assign w_owner[1]  = i_in.owner_y;
    assign w_owner[2]  = i_in.owner_z;
    assign w_facing[0] = i_in.facing_x;
    assign w_facing[1] = i_in.facing_y;
    assign w_facing[2] = i_in.facing_z;
    // Only the vertical axis gets the height offset.
    assign w_above[0]  = '0;
    assign w_above[1]  = '0;
    assign w_above[2]  = r_above;

    assign i_in.ready = &w_idle;
    assign w_start    = i_in.valid && i_in.ready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sfc_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (w_start),
            .i_snap   (i_in.command),
            .i_dt     (i_in.time_step),
            .i_owner  (w_owner[g]),
            .i_facing (w_facing[g]),
            .i_k      (r_k),
            .i_d      (r_d),
            .i_behind (r_behind),
            .i_look   (r_look),
            .i_above  (w_above[g]),
            .i_take   (w_take),
            .o_res    (w_res[g]),
            .o_idle   (w_idle[g])
        );
    end

    sfc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_take  (w_take),
        .o_out   (o_out)
    );

    `SFC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready, "input accepted while lanes were still busy")
    `SFC_ASSERT(a_lanes_lockstep, i_clk, i_rst_n, (w_res[0].done == w_res[1].done) && (w_res[1].done == w_res[2].done), "lanes finished out of step")
    `SFC_ASSERT_RST(a_reset_state, i_clk, !i_rst_n |=> (i_in.ready && !o_out.valid), "block not idle after reset")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sfc_pkg::*;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SNAP   = 1'b1;

    localparam int     FRAC   = FRAC_BITS_DEF;
    localparam longint Q_MAX  = 64'sd2147483647;
    localparam longint Q_MIN  = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd65536;
    localparam logic [CFG_W-1:0] REG_MAX = {CFG_W{1'b1}};

    typedef struct {
        logic                       command;
        logic [DT_W-1:0]            time_step;
        logic signed [DATA_W-1:0]   owner[3];
        logic signed [FACING_W-1:0] facing[3];
    } t_frame;

    // eye x/y/z followed by aim x/y/z
    typedef struct {
        logic [DATA_W-1:0] val[6];
    } t_view;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    sfc_in_if  in_bus ();
    sfc_out_if out_bus ();

    spring_follow_camera_step_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // Camera state and register copies used for prediction.
    longint eye_pos[3];
    longint eye_vel[3];
    longint spring_k, damping_d, behind_dist, above_dist, look_dist;
    longint walk_pos[3];

    t_frame frames_to_send[$];
    t_view  camera_views[$];
    t_frame frame_on_bus;
    int     send_wait;
    int     recv_wait;
    bit     send_burst;
    bit     recv_burst;
    int     mismatch_count;

    string field_name[6] = '{"eye_x", "eye_y", "eye_z", "aim_x", "aim_y", "aim_z"};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint clamp32(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Arithmetic shift of a signed product rounds toward minus infinity.
    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    function automatic longint dt_mul(longint a, longint dt);
        return clamp32((a * dt) >>> DT_W);
    endfunction

    function automatic t_view step_camera(t_frame f);
        longint own, fac, dt, diff, acc;
        longint ideal[3];
        longint aim[3];
        t_view v;
        dt = longint'(f.time_step);
        for (int i = 0; i < 3; i++) begin
            own = longint'(f.owner[i]);
            fac = longint'(f.facing[i]);
            ideal[i] = clamp32(own - fx_mul(fac, behind_dist));
            aim[i] = clamp32(own + fx_mul(fac, look_dist));
        end
        ideal[2] = clamp32(ideal[2] + above_dist);
        for (int i = 0; i < 3; i++) begin
            if (f.command == CMD_SNAP) begin
                eye_pos[i] = ideal[i];
                eye_vel[i] = 0;
            end else begin
                diff = clamp32(eye_pos[i] - ideal[i]);
                acc = clamp32(-fx_mul(spring_k, diff) - fx_mul(damping_d, eye_vel[i]));
                eye_vel[i] = clamp32(eye_vel[i] + dt_mul(acc, dt));
                eye_pos[i] = clamp32(eye_pos[i] + dt_mul(eye_vel[i], dt));
            end
            v.val[i] = DATA_W'(eye_pos[i]);
            v.val[3 + i] = DATA_W'(aim[i]);
        end
        return v;
    endfunction

    function automatic logic signed [FACING_W-1:0] any_facing();
        return FACING_W'(longint'($urandom_range(0, 131072)) - ONE_Q);
    endfunction

    // Mostly a moving owner with a near-unit heading and a frame-like time
    // step; the rest is full-range noise on the time step, owner and heading.
    function automatic t_frame make_frame();
        t_frame f;
        int r;
        longint hx, hy;
        r = $urandom_range(0, 99);
        f.command = (r < 6) ? CMD_SNAP : CMD_UPDATE;
        if (r >= 88) begin
            f.time_step = DT_W'($urandom);
            for (int i = 0; i < 3; i++) begin
                f.owner[i] = DATA_W'($urandom);
                f.facing[i] = any_facing();
            end
        end else begin
            f.time_step = (r < 10) ? '0 : DT_W'($urandom_range(500, 4000));
            for (int i = 0; i < 3; i++) begin
                walk_pos[i] = walk_pos[i] + longint'($urandom_range(0, 40 * 65536)) - 20 * ONE_Q;
                if (walk_pos[i] > (64'sd1 << 28)) walk_pos[i] = 64'sd1 << 28;
                if (walk_pos[i] < -(64'sd1 << 28)) walk_pos[i] = -(64'sd1 << 28);
                f.owner[i] = DATA_W'(walk_pos[i]);
            end
            hx = longint'($urandom_range(0, 131072)) - ONE_Q;
            hy = longint'($rtoi($sqrt(65536.0 * 65536.0 - real'(hx) * real'(hx))));
            if ($urandom_range(0, 1) == 1) hy = -hy;
            f.facing[0] = FACING_W'(hx);
            f.facing[1] = FACING_W'(hy);
            f.facing[2] = (r < 30) ? FACING_W'(longint'($urandom_range(0, 16384)) - 8192) : '0;
        end
        return f;
    endfunction

    task automatic push_frame(input logic cmd, input logic [DT_W-1:0] dt,
                              input longint ox, input longint oy, input longint oz,
                              input longint fx, input longint fy, input longint fz);
        t_frame f;
        f.command = cmd;
        f.time_step = dt;
        f.owner[0] = DATA_W'(ox);
        f.owner[1] = DATA_W'(oy);
        f.owner[2] = DATA_W'(oz);
        f.facing[0] = FACING_W'(fx);
        f.facing[1] = FACING_W'(fy);
        f.facing[2] = FACING_W'(fz);
        frames_to_send.push_back(f);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_SPRING:    spring_k = longint'(value);
            CFG_DAMPING:   damping_d = longint'(value);
            CFG_BEHIND:    behind_dist = longint'(value);
            CFG_ABOVE:     above_dist = longint'(value);
            CFG_LOOKAHEAD: look_dist = longint'(value);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_config(input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] d,
                               input logic [CFG_W-1:0] behind, input logic [CFG_W-1:0] above,
                               input logic [CFG_W-1:0] look);
        write_reg(CFG_SPRING, k);
        write_reg(CFG_DAMPING, d);
        write_reg(CFG_BEHIND, behind);
        write_reg(CFG_ABOVE, above);
        write_reg(CFG_LOOKAHEAD, look);
    endtask

    // A short margin after the last result leaves the lanes idle. The queues
    // and the valid line are checked at the falling edge, once the clocked
    // blocks settled.
    task automatic wait_idle();
        while (frames_to_send.size() != 0 || in_bus.valid || camera_views.size() != 0)
            @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                camera_views.push_back(step_camera(frame_on_bus));
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_bus.valid <= 1'b0;
                end else if (frames_to_send.size() != 0) begin
                    frame_on_bus = frames_to_send.pop_front();
                    in_bus.command <= frame_on_bus.command;
                    in_bus.time_step <= frame_on_bus.time_step;
                    in_bus.owner_x <= frame_on_bus.owner[0];
                    in_bus.owner_y <= frame_on_bus.owner[1];
                    in_bus.owner_z <= frame_on_bus.owner[2];
                    in_bus.facing_x <= frame_on_bus.facing[0];
                    in_bus.facing_y <= frame_on_bus.facing[1];
                    in_bus.facing_z <= frame_on_bus.facing[2];
                    in_bus.valid <= 1'b1;
                    if ($urandom_range(0, 47) == 0) send_burst = !send_burst;
                    send_wait = send_burst ? 0 : $urandom_range(0, 10);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] seen[6];
        t_view want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                seen = '{out_bus.eye_x, out_bus.eye_y, out_bus.eye_z,
                         out_bus.aim_x, out_bus.aim_y, out_bus.aim_z};
                if (camera_views.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    mismatch_count++;
                end else begin
                    want = camera_views.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (seen[i] !== want.val[i]) begin
                            $display("%0t: %s expected %h actual %h",
                                     $time, field_name[i], want.val[i], seen[i]);
                            mismatch_count++;
                        end
                    end
                end
                if ($urandom_range(0, 47) == 0) recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int s;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.command = CMD_UPDATE;
        in_bus.time_step = '0;
        in_bus.owner_x = '0;
        in_bus.owner_y = '0;
        in_bus.owner_z = '0;
        in_bus.facing_x = '0;
        in_bus.facing_y = '0;
        in_bus.facing_z = '0;
        out_bus.ready = 1'b0;
        mismatch_count = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        spring_k = 64 * ONE_Q;
        damping_d = 16 * ONE_Q;
        behind_dist = 350 * ONE_Q;
        above_dist = 150 * ONE_Q;
        look_dist = 100 * ONE_Q;
        for (int i = 0; i < 3; i++) begin
            eye_pos[i] = 0;
            eye_vel[i] = 0;
            walk_pos[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset register values.
        push_frame(CMD_UPDATE, 16'd0, 0, 0, 0, 0, 0, 0);
        push_frame(CMD_UPDATE, 16'd1092, 0, 0, 0, ONE_Q, 0, 0);
        push_frame(CMD_SNAP, 16'd0, 0, 0, 0, ONE_Q, 0, 0);
        push_frame(CMD_UPDATE, 16'hFFFF, Q_MAX, Q_MAX, Q_MAX, -ONE_Q, -ONE_Q, -ONE_Q);
        push_frame(CMD_UPDATE, 16'hFFFF, Q_MIN, Q_MIN, Q_MIN, ONE_Q, ONE_Q, ONE_Q);
        push_frame(CMD_SNAP, 16'hFFFF, Q_MAX, Q_MAX, Q_MAX, -ONE_Q, -ONE_Q, -ONE_Q);
        push_frame(CMD_UPDATE, 16'd0, Q_MIN, 0, Q_MAX, ONE_Q, -ONE_Q, 0);
        push_frame(CMD_SNAP, 16'd0, Q_MIN, Q_MIN, Q_MIN, ONE_Q, ONE_Q, ONE_Q);
        push_frame(CMD_UPDATE, 16'd1, Q_MAX, Q_MIN, 0, -ONE_Q, ONE_Q, -ONE_Q);
        // Non-unit heading is used as given.
        push_frame(CMD_UPDATE, 16'd1092, 100 * ONE_Q, -50 * ONE_Q, 7 * ONE_Q,
                   ONE_Q, ONE_Q, ONE_Q);
        push_frame(CMD_SNAP, 16'd1092, 10 * ONE_Q, 20 * ONE_Q, 30 * ONE_Q, 0, ONE_Q, 0);
        for (int i = 0; i < 6; i++)
            push_frame(CMD_UPDATE, 16'd1092, (10 + 3 * i) * ONE_Q, 20 * ONE_Q,
                       30 * ONE_Q, 0, ONE_Q, 0);
        push_frame(CMD_UPDATE, 16'h8000, -1, -1, -1, -1, -1, -1);
        push_frame(CMD_UPDATE, 16'h7FFF, 1, 1, 1, 1, 1, 1);
        push_frame(CMD_UPDATE, 16'd0, 5 * ONE_Q, 5 * ONE_Q, 5 * ONE_Q, 0, 0, ONE_Q);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: ;
                1: load_config(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
                2: load_config('0, '0, '0, '0, '0);
                5: load_config(CFG_W'(ONE_Q), CFG_W'(2 * ONE_Q), CFG_W'(5 * ONE_Q),
                               CFG_W'(2 * ONE_Q), CFG_W'(3 * ONE_Q));
                4, 8: load_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                  CFG_W'($urandom), CFG_W'($urandom));
                7: begin
                    // Stiff spring close to the top of the register range.
                    s = $urandom_range(150, 181);
                    load_config(CFG_W'(s * s * ONE_Q), CFG_W'(2 * s * ONE_Q),
                                CFG_W'($urandom_range(0, 2000) * ONE_Q),
                                CFG_W'($urandom_range(0, 2000) * ONE_Q),
                                CFG_W'($urandom_range(0, 2000) * ONE_Q));
                end
                9: load_config(CFG_W'(64 * ONE_Q), CFG_W'(16 * ONE_Q), CFG_W'(350 * ONE_Q),
                               CFG_W'(150 * ONE_Q), CFG_W'(100 * ONE_Q));
                default: begin
                    s = $urandom_range(1, 40);
                    load_config(CFG_W'(s * s * ONE_Q), CFG_W'(2 * s * ONE_Q),
                                CFG_W'($urandom_range(0, 1000) * ONE_Q),
                                CFG_W'($urandom_range(0, 1000) * ONE_Q),
                                CFG_W'($urandom_range(0, 1000) * ONE_Q));
                end
            endcase
            for (int n = 0; n < 145; n++)
                frames_to_send.push_back(make_frame());
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("spring_follow_camera_step_core regression: pass");
        end else begin
            $display("spring_follow_camera_step_core regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d results still expected", camera_views.size());
        $display("spring_follow_camera_step_core regression: fail");
        $finish;
    end

endmodule
